// ===== hw/rtl/vcsc_pkg.sv =====
// package: mode codes, register indexes and pipeline payload types for the color converter
package vcsc_pkg;

	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 8;

	// register indexes
	localparam logic [CfgIdxW-1:0] CFG_SOURCE_MODE = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_TARGET_MODE = 2'd1;

	// source modes (codes above gray16 decode as rgb)
	localparam logic [2:0] SRC_RGB    = 3'd0;
	localparam logic [2:0] SRC_RGBA   = 3'd1;
	localparam logic [2:0] SRC_CMYK   = 3'd2;
	localparam logic [2:0] SRC_GRAY8  = 3'd3;
	localparam logic [2:0] SRC_GRAY16 = 3'd4;

	// target modes
	localparam logic [1:0] TGT_RGB    = 2'd0;
	localparam logic [1:0] TGT_CMYK   = 2'd1;
	localparam logic [1:0] TGT_GRAY8  = 2'd2;
	localparam logic [1:0] TGT_GRAY16 = 2'd3;

	// floor(x/255) == (x * Recip255) >> 23 for any 16-bit x
	localparam logic [31:0] Recip255 = 32'd32897;
	// floor(s/3) == (s * Recip3) >> 11 for s up to 765
	localparam logic [20:0] Recip3   = 21'd683;

	typedef logic [7:0] chan_t;

	// payload after the first stage
	typedef struct packed {
		chan_t        a;
		chan_t        b;
		chan_t        c;
		chan_t        d;
		logic [15:0]  w;
		logic         last;
		logic [15:0]  p0;
		logic [15:0]  p1;
		logic [15:0]  p2;
		chan_t        wq;
	} s1_t;

	// payload from stage two onward
	typedef struct packed {
		chan_t        a;
		chan_t        b;
		chan_t        c;
		chan_t        d;
		logic [15:0]  w;
		logic         last;
		chan_t        r;
		chan_t        g;
		chan_t        bl;
		chan_t        gray8;
		chan_t        mx;
	} side_t;

endpackage

// ===== hw/rtl/vcsc_if.sv =====
// interfaces: voxel input channel, result channel and configuration write channel

interface vcsc_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  in_first;
	logic [7:0]  in_second;
	logic [7:0]  in_third;
	logic [7:0]  in_fourth;
	logic [15:0] in_wide_gray;
	logic        in_last;
	modport source (output valid, in_first, in_second, in_third, in_fourth, in_wide_gray,
		in_last, input ready);
	modport sink (input valid, in_first, in_second, in_third, in_fourth, in_wide_gray,
		in_last, output ready);
endinterface

interface vcsc_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_first;
	logic [7:0]  out_second;
	logic [7:0]  out_third;
	logic [7:0]  out_fourth;
	logic [15:0] out_wide_gray;
	logic        out_last;
	modport source (output valid, out_first, out_second, out_third, out_fourth, out_wide_gray,
		out_last, input ready);
	modport sink (input valid, out_first, out_second, out_third, out_fourth, out_wide_gray,
		out_last, output ready);
endinterface

interface vcsc_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/vcsc_divider.sv =====
// divider: three 16-by-8 bit quotients, two quotient bits per stage over four stages
module vcsc_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [15:0] num0,
	input  logic [15:0] num1,
	input  logic [15:0] num2,
	input  logic [7:0]  den,
	output logic        out_valid,
	output logic [7:0]  quo0,
	output logic [7:0]  quo1,
	output logic [7:0]  quo2
);
	import vcsc_pkg::*;

	// two restoring steps: quotient bits sh+1 and sh
	function automatic logic [17:0] step2(input logic [15:0] rem, input logic [7:0] dv,
		input int unsigned sh);
		logic [15:0] r;
		logic [15:0] t;
		logic [1:0]  q;
		r = rem;
		q = 2'b00;
		t = 16'(dv) << (sh + 1);
		if (r >= t) begin
			r = r - t;
			q[1] = 1'b1;
		end
		t = 16'(dv) << sh;
		if (r >= t) begin
			r = r - t;
			q[0] = 1'b1;
		end
		return {r, q};
	endfunction

	logic [15:0] rem_s1 [3], rem_s2 [3], rem_s3 [3];
	logic [7:0]  quo_s1 [3], quo_s2 [3], quo_s3 [3], quo_s4 [3];
	logic [7:0]  den_s1, den_s2, den_s3;
	logic        v_s1, v_s2, v_s3, v_s4;
	logic [15:0] num [3];
	logic [17:0] st1 [3], st2 [3], st3 [3], st4 [3];

	assign num[0] = num0;
	assign num[1] = num1;
	assign num[2] = num2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			st1[i] = step2(num[i], den, 6);
			st2[i] = step2(rem_s1[i], den_s1, 4);
			st3[i] = step2(rem_s2[i], den_s2, 2);
			st4[i] = step2(rem_s3[i], den_s3, 0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s1 <= den;
			den_s2 <= den_s1;
			den_s3 <= den_s2;
			for (int i = 0; i < 3; i++) begin
				rem_s1[i] <= st1[i][17:2];
				quo_s1[i] <= {st1[i][1:0], 6'd0};
				rem_s2[i] <= st2[i][17:2];
				quo_s2[i] <= {quo_s1[i][7:6], st2[i][1:0], 4'd0};
				rem_s3[i] <= st3[i][17:2];
				quo_s3[i] <= {quo_s2[i][7:4], st3[i][1:0], 2'd0};
				quo_s4[i] <= {quo_s3[i][7:2], st4[i][1:0]};
			end
		end
	end

	assign out_valid = v_s4;
	assign quo0 = quo_s4[0];
	assign quo1 = quo_s4[1];
	assign quo2 = quo_s4[2];

endmodule

// ===== hw/rtl/voxel_color_space_converter.sv =====
// top level: voxel color space converter, eight-stage pipeline
// throughput: one voxel per cycle unless stalled; stages 4 to 7 are the pipelined rgb-to-cmyk divider
// a stall at the result channel holds every stage at once; nothing is lost or repeated
// reset: arst_n clears all valid bits and sets both mode registers to rgb
module voxel_color_space_converter (
	input  logic clk,
	input  logic arst_n,
	vcsc_cfg_if.sink  cfg,
	vcsc_in_if.sink   pix_in,
	vcsc_out_if.source pix_out
);
	import vcsc_pkg::*;

	logic [2:0] source_mode_q;
	logic [1:0] target_mode_q;

	logic  en;
	logic  v_s1, v_s2, v_s3, v_div, v_s8;
	s1_t   st_s1;
	side_t side_s2, side_s3;
	side_t side_dly [4];
	side_t side_fin;
	logic [7:0] q0, q1, q2;

	// configuration: always ready, writes beyond the register list are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_mode_q <= SRC_RGB;
			target_mode_q <= TGT_RGB;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SOURCE_MODE: source_mode_q <= cfg.data[2:0];
				CFG_TARGET_MODE: target_mode_q <= cfg.data[1:0];
				default: ;
			endcase
		end
	end

	// whole pipeline advances when the output register is empty or being taken
	assign en = !v_s8 || pix_out.ready;
	assign pix_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s8 <= v_div;
		end
	end

	// stage 1: cmyk products c*(255-k) and gray16 / 255
	logic [7:0]  kinv;
	logic [31:0] wprod;
	logic [8:0]  wq9;
	always_comb begin
		kinv  = 8'd255 - pix_in.in_fourth;
		wprod = 32'(pix_in.in_wide_gray) * Recip255;
		wq9   = wprod[31:23];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1.a    <= pix_in.in_first;
			st_s1.b    <= pix_in.in_second;
			st_s1.c    <= pix_in.in_third;
			st_s1.d    <= pix_in.in_fourth;
			st_s1.w    <= pix_in.in_wide_gray;
			st_s1.last <= pix_in.in_last;
			st_s1.p0   <= 16'(pix_in.in_first) * 16'(kinv);
			st_s1.p1   <= 16'(pix_in.in_second) * 16'(kinv);
			st_s1.p2   <= 16'(pix_in.in_third) * 16'(kinv);
			// saturate gray16 beyond range to 255
			st_s1.wq   <= wq9[8] ? 8'd255 : wq9[7:0];
		end
	end

	// stage 2: finish cmyk to rgb, pick the rgb triple for the source mode
	function automatic logic [7:0] cmyk_to_rgb(input logic [15:0] p, input logic [7:0] k);
		logic [31:0] m;
		logic [8:0]  s;
		m = 32'(p) * Recip255;
		s = {1'b0, m[30:23]} + {1'b0, k};
		return s[8] ? 8'd0 : 8'd255 - s[7:0];
	endfunction

	side_t nx2;
	always_comb begin
		nx2       = '0;
		nx2.a     = st_s1.a;
		nx2.b     = st_s1.b;
		nx2.c     = st_s1.c;
		nx2.d     = st_s1.d;
		nx2.w     = st_s1.w;
		nx2.last  = st_s1.last;
		case (source_mode_q)
			SRC_CMYK: begin
				nx2.r  = cmyk_to_rgb(st_s1.p0, st_s1.d);
				nx2.g  = cmyk_to_rgb(st_s1.p1, st_s1.d);
				nx2.bl = cmyk_to_rgb(st_s1.p2, st_s1.d);
			end
			SRC_GRAY8: begin
				nx2.r  = st_s1.a;
				nx2.g  = st_s1.a;
				nx2.bl = st_s1.a;
			end
			SRC_GRAY16: begin
				nx2.r  = st_s1.wq;
				nx2.g  = st_s1.wq;
				nx2.bl = st_s1.wq;
			end
			default: begin
				nx2.r  = st_s1.a;
				nx2.g  = st_s1.b;
				nx2.bl = st_s1.c;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) side_s2 <= nx2;
	end

	// stage 3: gray mean, channel max, divider numerators (max - x) * 255
	side_t       nx3;
	logic [9:0]  sum3;
	logic [20:0] gprod;
	logic [7:0]  mx_rg;
	always_comb begin
		nx3   = side_s2;
		sum3  = 10'(side_s2.r) + 10'(side_s2.g) + 10'(side_s2.bl);
		gprod = 21'(sum3) * Recip3;
		nx3.gray8 = (source_mode_q == SRC_GRAY8) ? side_s2.a : gprod[18:11];
		mx_rg  = (side_s2.r > side_s2.g) ? side_s2.r : side_s2.g;
		nx3.mx = (mx_rg > side_s2.bl) ? mx_rg : side_s2.bl;
	end

	function automatic logic [15:0] times255(input logic [7:0] x);
		return {x, 8'd0} - {8'd0, x};
	endfunction

	logic [15:0] n0_s3, n1_s3, n2_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= nx3;
			n0_s3   <= times255(nx3.mx - side_s2.r);
			n1_s3   <= times255(nx3.mx - side_s2.g);
			n2_s3   <= times255(nx3.mx - side_s2.bl);
		end
	end

	// stages 4 to 7: divide by the channel max
	vcsc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.num0     (n0_s3),
		.num1     (n1_s3),
		.num2     (n2_s3),
		.den      (side_s3.mx),
		.out_valid(v_div),
		.quo0     (q0),
		.quo1     (q1),
		.quo2     (q2)
	);

	// side payload rides alongside the divider
	always_ff @(posedge clk) begin
		if (en) begin
			side_dly[0] <= side_s3;
			for (int i = 1; i < 4; i++) side_dly[i] <= side_dly[i-1];
		end
	end
	assign side_fin = side_dly[3];

	// stage 8: select the target format into the output register
	logic [7:0]  o1, o2, o3, o4;
	logic [15:0] ow;
	always_comb begin
		o1 = '0;
		o2 = '0;
		o3 = '0;
		o4 = '0;
		ow = '0;
		case (target_mode_q)
			TGT_RGB: begin
				o1 = side_fin.r;
				o2 = side_fin.g;
				o3 = side_fin.bl;
			end
			TGT_CMYK: begin
				if (source_mode_q == SRC_CMYK) begin
					o1 = side_fin.a;
					o2 = side_fin.b;
					o3 = side_fin.c;
					o4 = side_fin.d;
				end else begin
					// black key full: chromatic channels are zero
					if (side_fin.mx != 8'd0) begin
						o1 = q0;
						o2 = q1;
						o3 = q2;
					end
					o4 = 8'd255 - side_fin.mx;
				end
			end
			TGT_GRAY8: o1 = side_fin.gray8;
			default: begin
				ow = (source_mode_q == SRC_GRAY16) ? side_fin.w : times255(side_fin.gray8);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_out.out_first     <= o1;
			pix_out.out_second    <= o2;
			pix_out.out_third     <= o3;
			pix_out.out_fourth    <= o4;
			pix_out.out_wide_gray <= ow;
			pix_out.out_last      <= side_fin.last;
		end
	end

	assign pix_out.valid = v_s8;

`ifndef SYNTHESIS
	// gray8 target leaves the second, fourth and wide channels clear
	a_gray8_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s8 && target_mode_q == TGT_GRAY8) |->
		(pix_out.out_second == 8'd0 && pix_out.out_fourth == 8'd0
		&& pix_out.out_wide_gray == 16'd0))
		else $error("gray8 result carries data outside its channel");

	// gray16 target leaves the first and third 8-bit channels clear
	a_gray16_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s8 && target_mode_q == TGT_GRAY16) |->
		(pix_out.out_first == 8'd0 && pix_out.out_third == 8'd0))
		else $error("gray16 result carries 8-bit channel data");

	// converted cmyk: the channel at the max has zero ink
	a_cmyk_min_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s8 && target_mode_q == TGT_CMYK && source_mode_q != SRC_CMYK) |->
		(pix_out.out_first == 8'd0 || pix_out.out_second == 8'd0
		|| pix_out.out_third == 8'd0))
		else $error("rgb to cmyk result has no zero chromatic channel");

	// a stalled pipeline keeps its divider-side valid bit
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_div))
		else $error("pipeline moved during a stall");
`endif

endmodule

// ===== bench/vcsc_checker.sv =====
// checker: watches the voxel channels, predicts each converted color and compares
`timescale 1ns / 100ps

module vcsc_checker
	import vcsc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	vcsc_cfg_if cfg,
	vcsc_in_if  pix_in,
	vcsc_out_if pix_out,
	output int  fail_count,
	output int  pending_count
);

	typedef struct packed {
		logic [7:0]  first;
		logic [7:0]  second;
		logic [7:0]  third;
		logic [7:0]  fourth;
		logic [15:0] wide;
		logic        last;
	} color_t;

	logic [2:0] src_mode;
	logic [1:0] tgt_mode;
	color_t expected_colors[$];

	function automatic logic [7:0] cmyk_to_rgb_chan(logic [7:0] c, logic [7:0] k);
		int s;
		s = (int'(c) * (255 - int'(k))) / 255 + int'(k);
		if (s > 255)
			s = 255;
		return 8'(255 - s);
	endfunction

	function automatic color_t convert_color(logic [2:0] sm, logic [1:0] tm,
		logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d,
		logic [15:0] w, logic last);
		color_t o;
		int r, g, bl, gray, q, mx;
		o = '0;
		o.last = last;
		case (sm)
			SRC_CMYK: begin
				r = cmyk_to_rgb_chan(a, d);
				g = cmyk_to_rgb_chan(b, d);
				bl = cmyk_to_rgb_chan(c, d);
			end
			SRC_GRAY8: begin
				r = a; g = a; bl = a;
			end
			SRC_GRAY16: begin
				q = int'(w) / 255;
				if (q > 255)
					q = 255;
				r = q; g = q; bl = q;
			end
			default: begin
				r = a; g = b; bl = c;
			end
		endcase
		gray = (sm == SRC_GRAY8) ? int'(a) : (r + g + bl) / 3;
		case (tm)
			TGT_RGB: begin
				o.first = 8'(r); o.second = 8'(g); o.third = 8'(bl);
			end
			TGT_CMYK: begin
				if (sm == SRC_CMYK) begin
					o.first = a; o.second = b; o.third = c; o.fourth = d;
				end else begin
					mx = r > g ? r : g;
					mx = mx > bl ? mx : bl;
					// black key full leaves the chromatic channels at zero
					if (mx != 0) begin
						o.first = 8'(((mx - r) * 255) / mx);
						o.second = 8'(((mx - g) * 255) / mx);
						o.third = 8'(((mx - bl) * 255) / mx);
					end
					o.fourth = 8'(255 - mx);
				end
			end
			TGT_GRAY8: o.first = 8'(gray);
			default: o.wide = (sm == SRC_GRAY16) ? w : 16'(gray * 255);
		endcase
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	assign pending_count = expected_colors.size();

	always @(posedge clk or negedge arst_n) begin
		color_t want;
		if (!arst_n) begin
			src_mode <= SRC_RGB;
			tgt_mode <= TGT_RGB;
			fail_count = 0;
			expected_colors.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_SOURCE_MODE)
					src_mode <= cfg.data[2:0];
				else if (cfg.index == CFG_TARGET_MODE)
					tgt_mode <= cfg.data[1:0];
			end
			if (pix_in.valid && pix_in.ready)
				expected_colors.push_back(convert_color(src_mode, tgt_mode,
					pix_in.in_first, pix_in.in_second, pix_in.in_third, pix_in.in_fourth,
					pix_in.in_wide_gray, pix_in.in_last));
			if (pix_out.valid && pix_out.ready) begin
				if (expected_colors.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					want = expected_colors.pop_front();
					if (pix_out.out_first !== want.first)
						report_mismatch("out_first", pix_out.out_first, want.first);
					if (pix_out.out_second !== want.second)
						report_mismatch("out_second", pix_out.out_second, want.second);
					if (pix_out.out_third !== want.third)
						report_mismatch("out_third", pix_out.out_third, want.third);
					if (pix_out.out_fourth !== want.fourth)
						report_mismatch("out_fourth", pix_out.out_fourth, want.fourth);
					if (pix_out.out_wide_gray !== want.wide)
						report_mismatch("out_wide_gray", pix_out.out_wide_gray, want.wide);
					if (pix_out.out_last !== want.last)
						report_mismatch("out_last", pix_out.out_last, want.last);
				end
			end
		end
	end

endmodule

// ===== bench/voxel_color_space_converter_test.sv =====
// testbench top: drives voxel stimulus and mode writes, gives the verdict
`timescale 1ns / 100ps

module voxel_color_space_converter_test;
	import vcsc_pkg::*;

	localparam int PipeLatency = 8;
	localparam int IdleLimit   = 2000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_count;
	int   idle_cycles;
	logic hold_off;

	vcsc_cfg_if cfg();
	vcsc_in_if  pix_in();
	vcsc_out_if pix_out();

	voxel_color_space_converter dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .pix_in(pix_in), .pix_out(pix_out)
	);

	vcsc_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .pix_in(pix_in), .pix_out(pix_out),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// write one mode register; only called while the pipeline is empty
	task automatic write_mode(logic [CfgIdxW-1:0] idx, logic [7:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// offer one voxel after a random gap, wait for its transaction
	task automatic send_voxel(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d,
		logic [15:0] w, logic last);
		int gap;
		gap = $urandom_range(0, 4);
		// some stretches go back to back
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			pix_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_in.valid        <= 1'b1;
		pix_in.in_first     <= a;
		pix_in.in_second    <= b;
		pix_in.in_third     <= c;
		pix_in.in_fourth    <= d;
		pix_in.in_wide_gray <= w;
		pix_in.in_last      <= last;
		do @(posedge clk); while (!pix_in.ready);
	endtask

	task automatic send_random_voxel();
		send_voxel($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	// drain the pipeline before touching the mode registers
	task automatic wait_drained();
		pix_in.valid <= 1'b0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (PipeLatency + 2) @(posedge clk);
	endtask

	task automatic set_modes(logic [7:0] sm, logic [7:0] tm);
		wait_drained();
		write_mode(CFG_SOURCE_MODE, sm);
		write_mode(CFG_TARGET_MODE, tm);
	endtask

	// result side: random stalls, plus one long hold-off to fill the pipeline
	initial begin
		int stall;
		pix_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				pix_out.ready <= 1'b0;
				repeat (60) @(posedge clk);
				hold_off = 1'b0;
			end else begin
				stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
				if (stall != 0) begin
					pix_out.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			pix_out.ready <= 1'b1;
			do @(posedge clk); while (!pix_out.valid);
		end
	end

	// watchdog: cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
			(cfg.valid && cfg.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IdleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		logic [7:0] sm, tm;
		idle_cycles = 0;
		hold_off = 1'b0;
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		pix_in.valid = 1'b0;
		pix_in.in_first = '0;
		pix_in.in_second = '0;
		pix_in.in_third = '0;
		pix_in.in_fourth = '0;
		pix_in.in_wide_gray = '0;
		pix_in.in_last = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes under reset modes (rgb to rgb)
		send_voxel(8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 1'b0);
		send_voxel(8'd255, 8'd255, 8'd255, 8'd255, 16'hffff, 1'b1);
		// rgb to cmyk: black key full and ordinary color
		set_modes(SRC_RGB, TGT_CMYK);
		send_voxel(8'd0, 8'd0, 8'd0, 8'd9, 16'd0, 1'b0);
		send_voxel(8'd200, 8'd100, 8'd1, 8'd0, 16'd0, 1'b0);
		send_voxel(8'd255, 8'd0, 8'd128, 8'd0, 16'd0, 1'b1);
		// cmyk to rgb, gray and cmyk
		set_modes(SRC_CMYK, TGT_RGB);
		send_voxel(8'd255, 8'd0, 8'd100, 8'd255, 16'd0, 1'b0);
		send_voxel(8'd255, 8'd200, 8'd10, 8'd30, 16'd0, 1'b0);
		set_modes(SRC_CMYK, TGT_GRAY16);
		send_voxel(8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 1'b1);
		set_modes(SRC_CMYK, TGT_CMYK);
		send_voxel(8'd1, 8'd2, 8'd3, 8'd4, 16'd0, 1'b0);
		// gray16 beyond range saturates
		set_modes(SRC_GRAY16, TGT_GRAY8);
		send_voxel(8'd0, 8'd0, 8'd0, 8'd0, 16'd65279, 1'b0);
		send_voxel(8'd0, 8'd0, 8'd0, 8'd0, 16'd65280, 1'b0);
		send_voxel(8'd0, 8'd0, 8'd0, 8'd0, 16'hffff, 1'b1);
		set_modes(SRC_GRAY16, TGT_CMYK);
		send_voxel(8'd7, 8'd7, 8'd7, 8'd7, 16'd300, 1'b0);
		set_modes(SRC_GRAY8, TGT_GRAY16);
		send_voxel(8'd255, 8'd1, 8'd2, 8'd3, 16'd5, 1'b0);
		set_modes(SRC_RGBA, TGT_GRAY8);
		send_voxel(8'd255, 8'd255, 8'd254, 8'd77, 16'd0, 1'b0);
		// unused source code decodes as rgb; out-of-range index ignored
		set_modes(8'd7, TGT_CMYK);
		write_mode(2'd3, 8'hff);
		write_mode(2'd2, 8'h00);
		send_voxel(8'd10, 8'd20, 8'd30, 8'd40, 16'd50, 1'b0);

		// random phases, each with its own mode pair
		for (int phase = 0; phase < 20; phase++) begin
			sm = (phase < 8) ? 8'(phase) : 8'($urandom_range(0, 7));
			tm = (phase < 4) ? 8'(phase) : 8'($urandom_range(0, 3));
			// upper data bits exercised too
			sm[7:3] = 5'($urandom);
			tm[7:2] = 6'($urandom);
			set_modes(sm, tm);
			if (phase == 10) begin
				wait_drained();
				hold_off = 1'b1;
			end
			for (int n = 0; n < 50; n++)
				send_random_voxel();
		end

		wait_drained();
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/vcsc_pkg.sv
hw/rtl/vcsc_if.sv
hw/rtl/vcsc_divider.sv
hw/rtl/voxel_color_space_converter.sv
bench/vcsc_checker.sv
bench/voxel_color_space_converter_test.sv
